FILE: sv/msp_pkg.sv
package msp_pkg;

    localparam int REQ_W    = 3;
    localparam int HANDLE_W = 5;
    localparam int DEST_W   = 8;
    localparam int STATUS_W = 9;

    // Request codes; the remaining three codes of the field are unknown requests.
    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 3'd0,
        REQ_FREE    = 3'd1,
        REQ_SEND    = 3'd2,
        REQ_RECEIVE = 3'd3,
        REQ_STATUS  = 3'd4
    } t_req;

    localparam logic [STATUS_W-1:0] ST_AVAILABLE = 9'h000;
    localparam logic [STATUS_W-1:0] ST_CLAIMED   = 9'h1FF;

    // One request as it travels down the row of slot cells.
    typedef struct packed {
        logic                valid;
        t_req                req;
        logic [HANDLE_W-1:0] handle;
        logic [DEST_W-1:0]   dest;
        logic                found;
        logic [HANDLE_W-1:0] found_idx;
    } t_wave;

endpackage

FILE: sv/msp_cell.sv
module msp_cell #(
    parameter int unsigned INDEX = 0,
    parameter int          CNT_W = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  msp_pkg::t_wave      i_wave,
    input  logic [CNT_W-1:0]    i_cnt_av,
    input  logic [CNT_W-1:0]    i_cnt_cl,
    input  logic [CNT_W-1:0]    i_cnt_pd,
    output msp_pkg::t_wave      o_wave,
    output logic [CNT_W-1:0]    o_cnt_av,
    output logic [CNT_W-1:0]    o_cnt_cl,
    output logic [CNT_W-1:0]    o_cnt_pd
);

    logic [msp_pkg::STATUS_W-1:0] r_status;
    logic [msp_pkg::STATUS_W-1:0] n_status;
    msp_pkg::t_wave               r_wave;
    msp_pkg::t_wave               n_wave;
    logic [CNT_W-1:0]             r_cnt_av, r_cnt_cl, r_cnt_pd;
    logic [CNT_W-1:0]             n_cnt_av, n_cnt_cl, n_cnt_pd;
    logic                         hit;
    logic                         is_av;
    logic                         is_cl;

    assign hit   = (32'(i_wave.handle) == INDEX);
    assign is_av = (r_status == msp_pkg::ST_AVAILABLE);
    assign is_cl = (r_status == msp_pkg::ST_CLAIMED);

    always_comb begin
        n_status = r_status;
        n_wave   = i_wave;
        n_cnt_av = i_cnt_av;
        n_cnt_cl = i_cnt_cl;
        n_cnt_pd = i_cnt_pd;
        if (i_wave.valid) begin
            case (i_wave.req)
                msp_pkg::REQ_ALLOC: begin
                    if (!i_wave.found && is_av) begin
                        n_status         = msp_pkg::ST_CLAIMED;
                        n_wave.found     = 1'b1;
                        n_wave.found_idx = msp_pkg::HANDLE_W'(INDEX);
                    end
                end
                msp_pkg::REQ_FREE: begin
                    if (hit) begin
                        n_status = msp_pkg::ST_AVAILABLE;
                    end
                end
                msp_pkg::REQ_SEND: begin
                    if (hit) begin
                        n_status = {1'b0, i_wave.dest};
                    end
                end
                msp_pkg::REQ_RECEIVE: begin
                    if (!i_wave.found && r_status == {1'b0, i_wave.dest}) begin
                        n_wave.found     = 1'b1;
                        n_wave.found_idx = msp_pkg::HANDLE_W'(INDEX);
                    end
                end
                msp_pkg::REQ_STATUS: begin
                    if (is_av) begin
                        n_cnt_av = i_cnt_av + CNT_W'(1);
                    end else if (is_cl) begin
                        n_cnt_cl = i_cnt_cl + CNT_W'(1);
                    end else begin
                        n_cnt_pd = i_cnt_pd + CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Only the slot and the valid flag are reset; the payload simply follows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status     <= msp_pkg::ST_AVAILABLE;
            r_wave.valid <= 1'b0;
        end else if (i_adv) begin
            r_status <= n_status;
            r_wave   <= n_wave;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cnt_av <= n_cnt_av;
            r_cnt_cl <= n_cnt_cl;
            r_cnt_pd <= n_cnt_pd;
        end
    end

    assign o_wave   = r_wave;
    assign o_cnt_av = r_cnt_av;
    assign o_cnt_cl = r_cnt_cl;
    assign o_cnt_pd = r_cnt_pd;

endmodule

FILE: sv/message_slot_pool.sv
// Status keeper for a fixed pool of message slots. Each slot is available,
// claimed, or pending for a destination from 1 to 255.
// The slave channel (i_s_tvalid, o_s_tready, i_s_tdata) carries one request
// per beat: allocate, free, send, receive or status. The master channel
// (o_m_tvalid, i_m_tready, o_m_tdata) returns exactly one result beat per
// request, in request order.
// Every slot lives in its own cell, and the cells form a row. A request
// enters the first cell and moves one cell per cycle while the row advances;
// each cell looks at its own slot, updates it, and passes the request with
// the search result and the running counts to its neighbor. Because every cell
// sees requests in arrival order, a new request may follow in the next cycle.
// From the accepted request beat, a request passes the register of every cell
// in the row and then the output register before its result beat goes out.
// Throughput is one request per cycle while the receiver takes results.
// When the receiver stalls with a result waiting, the whole row holds and
// o_s_tready drops in the same cycle.
// Reset makes every slot available and empties the row and output register.
module message_slot_pool #(
    parameter int SLOT_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // Fields from bit 0 up: req_type[2:0], slot_handle[7:3], dest_id[15:8].
    input  logic [15:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // Fields from bit 0 up: op_ok[0], found_handle[5:1], count_available[10:6],
    // count_claimed[15:11], count_pending[20:16], zero fill[23:21].
    output logic [23:0] o_m_tdata
);

    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [msp_pkg::HANDLE_W-1:0] NONE_HANDLE =
        msp_pkg::HANDLE_W'(SLOT_COUNT);

    // The row advances only when the output register is free or being drained.
    logic                      adv;
    msp_pkg::t_wave            wave   [0:SLOT_COUNT];
    logic [CNT_W-1:0]          cnt_av [0:SLOT_COUNT];
    logic [CNT_W-1:0]          cnt_cl [0:SLOT_COUNT];
    logic [CNT_W-1:0]          cnt_pd [0:SLOT_COUNT];
    msp_pkg::t_wave            tail;
    logic                      ok;
    logic [CNT_W:0]            cnt_sum;

    logic                      r_out_valid;
    logic [23:0]               r_out_data;
    logic [23:0]               n_out_data;

    assign adv        = !r_out_valid || i_m_tready;
    assign o_s_tready = adv;

    always_comb begin
        wave[0].valid     = i_s_tvalid;
        wave[0].req       = msp_pkg::t_req'(i_s_tdata[2:0]);
        wave[0].handle    = i_s_tdata[7:3];
        wave[0].dest      = i_s_tdata[15:8];
        wave[0].found     = 1'b0;
        wave[0].found_idx = NONE_HANDLE;
    end

    assign cnt_av[0] = '0;
    assign cnt_cl[0] = '0;
    assign cnt_pd[0] = '0;

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        msp_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (adv),
            .i_wave   (wave[g]),
            .i_cnt_av (cnt_av[g]),
            .i_cnt_cl (cnt_cl[g]),
            .i_cnt_pd (cnt_pd[g]),
            .o_wave   (wave[g+1]),
            .o_cnt_av (cnt_av[g+1]),
            .o_cnt_cl (cnt_cl[g+1]),
            .o_cnt_pd (cnt_pd[g+1])
        );
    end

    assign tail = wave[SLOT_COUNT];

    // Allocate and receive succeed when some cell took the search; free and
    // send succeed for an in-range handle; the status request always succeeds.
    always_comb begin
        case (tail.req)
            msp_pkg::REQ_ALLOC:   ok = tail.found;
            msp_pkg::REQ_RECEIVE: ok = tail.found;
            msp_pkg::REQ_FREE:    ok = (32'(tail.handle) < SLOT_COUNT);
            msp_pkg::REQ_SEND:    ok = (32'(tail.handle) < SLOT_COUNT);
            msp_pkg::REQ_STATUS:  ok = 1'b1;
            default:              ok = 1'b0;
        endcase
    end

    // Counts only grow on a status request, so they are zero for every other kind.
    always_comb begin
        n_out_data        = '0;
        n_out_data[0]     = ok;
        n_out_data[5:1]   = tail.found ? tail.found_idx : NONE_HANDLE;
        n_out_data[10:6]  = 5'(cnt_av[SLOT_COUNT]);
        n_out_data[15:11] = 5'(cnt_cl[SLOT_COUNT]);
        n_out_data[20:16] = 5'(cnt_pd[SLOT_COUNT]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= tail.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign cnt_sum = (CNT_W + 1)'(cnt_av[SLOT_COUNT]) + (CNT_W + 1)'(cnt_cl[SLOT_COUNT])
                   + (CNT_W + 1)'(cnt_pd[SLOT_COUNT]);

`ifndef SYNTHESIS
    // A status request leaving the row has classified every slot exactly once.
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tail.valid && tail.req == msp_pkg::REQ_STATUS) |-> (32'(cnt_sum) == SLOT_COUNT))
        else $error("slot counts do not add up to the pool size");

    // Only a search request can come out of the row with a slot found.
    a_found_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tail.valid && tail.found) |->
            (tail.req == msp_pkg::REQ_ALLOC || tail.req == msp_pkg::REQ_RECEIVE))
        else $error("found flag set on a request that does not search");

    // While the receiver stalls, the last cell's request is held for the next edge.
    a_row_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> $stable(tail))
        else $error("row advanced during an output stall");
`endif

endmodule

FILE: bench/message_slot_pool_checker.sv
module message_slot_pool_checker #(
    parameter int SLOT_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // Fields from bit 0 up: req_type[2:0], slot_handle[7:3], dest_id[15:8].
    input  logic [15:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // Fields from bit 0 up: op_ok[0], found_handle[5:1], count_available[10:6],
    // count_claimed[15:11], count_pending[20:16], zero fill[23:21].
    input  logic [23:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REQ_W    = msp_pkg::REQ_W;
    localparam int HANDLE_W = msp_pkg::HANDLE_W;
    localparam int DEST_W   = msp_pkg::DEST_W;
    localparam int STATUS_W = msp_pkg::STATUS_W;
    localparam logic [HANDLE_W-1:0] NONE_HANDLE = HANDLE_W'(SLOT_COUNT);

    typedef struct packed {
        logic [HANDLE_W-1:0] pending;
        logic [HANDLE_W-1:0] claimed;
        logic [HANDLE_W-1:0] available;
        logic [HANDLE_W-1:0] handle;
        logic                ok;
    } t_pool_result;

    logic [STATUS_W-1:0] slot_state [SLOT_COUNT];
    t_pool_result        pool_results_q [$];
    t_pool_result        want_result;
    t_pool_result        got_result;
    int                  fail_count = 0;
    int                  due_count = 0;

    assign o_fail_count  = fail_count;
    assign o_results_due = due_count;

    function automatic int first_slot_with(logic [STATUS_W-1:0] status);
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_state[i] == status) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one request to the shadow pool and returns the result it gives.
    function automatic t_pool_result pool_apply(logic [REQ_W-1:0] kind,
                                                logic [HANDLE_W-1:0] handle,
                                                logic [DEST_W-1:0] dest);
        t_pool_result r;
        int           idx;
        int           n_av;
        int           n_cl;
        int           n_pd;
        r = '0;
        r.handle = NONE_HANDLE;
        n_av = 0;
        n_cl = 0;
        n_pd = 0;
        case (msp_pkg::t_req'(kind))
            msp_pkg::REQ_ALLOC: begin
                idx = first_slot_with(msp_pkg::ST_AVAILABLE);
                if (idx >= 0) begin
                    slot_state[idx] = msp_pkg::ST_CLAIMED;
                    r.ok = 1'b1;
                    r.handle = HANDLE_W'(idx);
                end
            end
            msp_pkg::REQ_FREE: begin
                if (int'(handle) < SLOT_COUNT) begin
                    slot_state[handle] = msp_pkg::ST_AVAILABLE;
                    r.ok = 1'b1;
                end
            end
            msp_pkg::REQ_SEND: begin
                if (int'(handle) < SLOT_COUNT) begin
                    slot_state[handle] = {1'b0, dest};
                    r.ok = 1'b1;
                end
            end
            msp_pkg::REQ_RECEIVE: begin
                // Id zero matches an available slot, like any other status word.
                idx = first_slot_with({1'b0, dest});
                if (idx >= 0) begin
                    r.ok = 1'b1;
                    r.handle = HANDLE_W'(idx);
                end
            end
            msp_pkg::REQ_STATUS: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (slot_state[i] == msp_pkg::ST_AVAILABLE) begin
                        n_av++;
                    end else if (slot_state[i] == msp_pkg::ST_CLAIMED) begin
                        n_cl++;
                    end else begin
                        n_pd++;
                    end
                end
                r.ok = 1'b1;
                r.available = HANDLE_W'(n_av);
                r.claimed = HANDLE_W'(n_cl);
                r.pending = HANDLE_W'(n_pd);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [HANDLE_W-1:0] want,
                               logic [HANDLE_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_state[i] = msp_pkg::ST_AVAILABLE;
            end
            pool_results_q.delete();
            due_count = 0;
        end else begin
            // Results leave long after their request, so the pop goes first.
            if (i_m_tvalid && i_m_tready) begin
                got_result = t_pool_result'(i_m_tdata[20:0]);
                if (pool_results_q.size() == 0) begin
                    $error("result beat with no request waiting: %h", i_m_tdata);
                    fail_count++;
                end else begin
                    want_result = pool_results_q.pop_front();
                    due_count--;
                    check_field("op_ok", HANDLE_W'(want_result.ok),
                                HANDLE_W'(got_result.ok));
                    check_field("found_handle", want_result.handle, got_result.handle);
                    check_field("count_available", want_result.available,
                                got_result.available);
                    check_field("count_claimed", want_result.claimed,
                                got_result.claimed);
                    check_field("count_pending", want_result.pending,
                                got_result.pending);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                pool_results_q.push_back(pool_apply(i_s_tdata[2:0], i_s_tdata[7:3],
                                                    i_s_tdata[15:8]));
                due_count++;
            end
        end
    end

endmodule

FILE: bench/message_slot_pool_tb.sv
module message_slot_pool_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT = 16;
    localparam int REQ_W    = msp_pkg::REQ_W;
    localparam int HANDLE_W = msp_pkg::HANDLE_W;
    localparam int DEST_W   = msp_pkg::DEST_W;
    // The row is one cell per slot plus the output register.
    localparam int PIPE_LATENCY = SLOT_COUNT + 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 170;

    // Request codes that the block does not know; they must change nothing.
    localparam logic [REQ_W-1:0] REQ_UNKNOWN_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN_HI = 3'd7;
    localparam logic [HANDLE_W-1:0] NULL_HANDLE = HANDLE_W'(SLOT_COUNT);

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;

    int fail_count;
    int results_due;
    int cycle_count = 0;
    int send_idle_pct = 16;
    int recv_idle_pct = 51;

    // Destination ids that come up often, so that receives find their slots.
    logic [DEST_W-1:0] common_dest [5] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd255};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    message_slot_pool #(
        .SLOT_COUNT(SLOT_COUNT)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata)
    );

    message_slot_pool_checker #(
        .SLOT_COUNT(SLOT_COUNT)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_results_due(results_due)
    );

    // The receiver decides afresh at every edge whether it takes a result beat.
    // One nonblocking assignment per edge keeps the ready level unambiguous.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] make_request(logic [REQ_W-1:0] kind,
                                                 logic [HANDLE_W-1:0] handle,
                                                 logic [DEST_W-1:0] dest);
        return {dest, handle, kind};
    endfunction

    // Offers one request beat and returns in the time step of its acceptance.
    // Idle cycles come first, so a held valid is never lowered and raised in
    // the same step.
    task automatic push_beat(logic [15:0] beat);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= beat;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
    endtask

    // Holds the sender back until every request has come back as a result.
    // The count is sampled on the falling edge, away from the checker's update.
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (results_due != 0);
        @(posedge i_clk);
    endtask

    // A stretch of random requests. Handles are mostly real slots and ids
    // mostly a few common values, so sends and receives meet each other; the
    // rest is full-range noise, null handles and unknown request codes. The
    // share of allocates steers the pool toward full or toward empty.
    task automatic run_random_phase(int alloc_pct);
        logic [REQ_W-1:0]    kind;
        logic [HANDLE_W-1:0] handle;
        logic [DEST_W-1:0]   dest;
        int                  pick;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            if (pick < alloc_pct) begin
                kind = msp_pkg::REQ_ALLOC;
            end else begin
                pick = $urandom_range(99);
                if (pick < 25) begin
                    kind = msp_pkg::REQ_FREE;
                end else if (pick < 55) begin
                    kind = msp_pkg::REQ_SEND;
                end else if (pick < 80) begin
                    kind = msp_pkg::REQ_RECEIVE;
                end else if (pick < 93) begin
                    kind = msp_pkg::REQ_STATUS;
                end else begin
                    kind = REQ_W'($urandom_range(REQ_UNKNOWN_HI, REQ_UNKNOWN_LO));
                end
            end
            if ($urandom_range(9) == 0) begin
                handle = HANDLE_W'($urandom_range(31));
            end else begin
                handle = HANDLE_W'($urandom_range(SLOT_COUNT - 1));
            end
            if ($urandom_range(4) == 0) begin
                dest = DEST_W'($urandom_range(255));
            end else begin
                dest = common_dest[$urandom_range(4)];
            end
            push_beat(make_request(kind, handle, dest));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A fresh pool reports sixteen available slots, and
        // receive with id zero finds the first available one.
        push_beat(make_request(msp_pkg::REQ_STATUS, '0, '0));
        push_beat(make_request(msp_pkg::REQ_RECEIVE, '0, 8'd0));
        push_beat(make_request(msp_pkg::REQ_RECEIVE, '0, 8'd255));
        // Out-of-range handles: the null handle and the all-ones handle.
        push_beat(make_request(msp_pkg::REQ_FREE, NULL_HANDLE, '0));
        push_beat(make_request(msp_pkg::REQ_SEND, 5'd31, 8'd255));
        // Fill the pool, then one allocate too many sees it full.
        for (int n = 0; n <= SLOT_COUNT; n++) begin
            push_beat(make_request(msp_pkg::REQ_ALLOC, '0, '0));
        end
        // Send works on a claimed slot; destination zero frees a slot.
        push_beat(make_request(msp_pkg::REQ_SEND, 5'd15, 8'd255));
        push_beat(make_request(msp_pkg::REQ_SEND, 5'd3, 8'd0));
        push_beat(make_request(msp_pkg::REQ_RECEIVE, 5'd31, 8'd255));
        push_beat(make_request(msp_pkg::REQ_STATUS, 5'd31, 8'd255));
        push_beat(make_request(msp_pkg::REQ_FREE, 5'd0, 8'd255));
        // Send to a slot that is already available leaves it pending.
        push_beat(make_request(msp_pkg::REQ_SEND, 5'd0, 8'd1));
        push_beat(make_request(REQ_UNKNOWN_HI, 5'd31, 8'd255));
        push_beat(make_request(REQ_UNKNOWN_LO, 5'd0, 8'd0));

        // Random part, first with a slow receiver and a mostly eager sender.
        run_random_phase(35);
        wait_results_done();

        send_idle_pct <= 51;
        recv_idle_pct <= 16;
        run_random_phase(10);
        wait_results_done();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        run_random_phase(25);
        s_tvalid <= 1'b0;

        // Drain: every result back, then a quiet wait, longer than the pipeline,
        // in which no stray result beat may appear.
        do begin
            @(negedge i_clk);
        end while (results_due != 0);
        repeat (PIPE_LATENCY + 4) @(negedge i_clk);

        if (fail_count == 0 && results_due == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/msp_pkg.sv
sv/msp_cell.sv
sv/message_slot_pool.sv
bench/message_slot_pool_checker.sv
bench/message_slot_pool_tb.sv
